// ===== hw/rtl/gbem_pkg.sv =====
// ----------------------------------------------------------------------------
// gbem_pkg
// Shared constants, types and ROM tables of the grain-boundary energy and
// mobility pipeline.
// ----------------------------------------------------------------------------
package gbem_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int LOG_BITS  = $clog2(LOG_DEPTH);
    localparam int EXP_DEPTH = 256;
    localparam int EXP_BITS  = $clog2(EXP_DEPTH);

    localparam int ANG_W = 16;
    localparam int LN_W  = 31;
    localparam int EXP_W = 31;
    localparam int DIV_W = 50;

    localparam logic [63:0] EXP_STEP = (64'd8 << 30) / 64'(EXP_DEPTH);

    localparam logic [1:0] REG_ANGLE    = 2'd0;
    localparam logic [1:0] REG_ENERGY   = 2'd1;
    localparam logic [1:0] REG_MOBILITY = 2'd2;

    typedef logic [LN_W-1:0]  ln_rom_t  [0:LOG_DEPTH];
    typedef logic [EXP_W-1:0] exp_rom_t [0:EXP_DEPTH];

    typedef struct packed {
        logic zero;
        logic gt;
        logic neg;
    } side_t;

    function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = 64'd0;
        rem = 65'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic ln_rom_t build_ln_rom();
        ln_rom_t     rom;
        logic [63:0] d;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] sum;
        d = 64'(LOG_DEPTH);
        for (int i = 0; i <= LOG_DEPTH; i++) begin
            u   = const_udiv(64'(i) << 30, 2 * d + 64'(i));
            u2  = (u * u) >> 30;
            p   = u;
            sum = 64'd0;
            for (int k = 0; k < 64; k++) begin
                if (p != 64'd0) begin
                    sum = sum + const_udiv(p, 64'(2 * k + 1));
                    p   = (p * u2) >> 30;
                end
            end
            rom[i] = LN_W'(2 * sum);
        end
        return rom;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] prev;
        logic [63:0] prod;
        s    = EXP_STEP;
        r    = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                term = const_udiv((term * s) >> 30, 64'(n));
                if ((n % 2) == 1) begin
                    r = r - term;
                end else begin
                    r = r + term;
                end
            end
        end
        prev   = 64'd1 << 30;
        rom[0] = EXP_W'(prev);
        for (int i = 1; i <= EXP_DEPTH; i++) begin
            prod   = prev * r;
            prev   = (prod + (64'd1 << 29)) >> 30;
            rom[i] = EXP_W'(prev);
        end
        return rom;
    endfunction

    localparam ln_rom_t  LN_ROM  = build_ln_rom();
    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== hw/rtl/gbem_div.sv =====
// ----------------------------------------------------------------------------
// gbem_div
// Pipelined restoring divider: two dividends over one 16 bit divisor, one
// quotient bit per stage, side flags and valid travelling alongside.
// ----------------------------------------------------------------------------
module gbem_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [gbem_pkg::DIV_W-1:0]     in_num_a,
    input  logic [gbem_pkg::DIV_W-1:0]     in_num_b,
    input  gbem_pkg::side_t                in_side,
    input  logic [15:0]                    divisor,
    output logic                           out_valid,
    output logic [gbem_pkg::DIV_W-1:0]     out_q_a,
    output logic [gbem_pkg::DIV_W-1:0]     out_q_b,
    output gbem_pkg::side_t                out_side
);

    localparam int W = gbem_pkg::DIV_W;

    logic [15:0]     ra_reg   [0:W-1];
    logic [W-1:0]    qa_reg   [0:W-1];
    logic [15:0]     rb_reg   [0:W-1];
    logic [W-1:0]    qb_reg   [0:W-1];
    gbem_pkg::side_t side_reg [0:W-1];
    logic            vld_reg  [0:W-1];

    logic [15:0]     ra_next   [0:W-1];
    logic [W-1:0]    qa_next   [0:W-1];
    logic [15:0]     rb_next   [0:W-1];
    logic [W-1:0]    qb_next   [0:W-1];
    gbem_pkg::side_t side_next [0:W-1];
    logic            vld_next  [0:W-1];

    function automatic logic [W+15:0] div_step(input logic [15:0] rem,
                                               input logic [W-1:0] nq,
                                               input logic [15:0] d);
        logic [16:0] t;
        logic        ge;
        logic [15:0] r;
        t  = {rem, nq[W-1]};
        ge = (t >= {1'b0, d});
        r  = ge ? 16'(t - {1'b0, d}) : t[15:0];
        return {r, nq[W-2:0], ge};
    endfunction

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            if (k == 0) begin : g_first
                assign {ra_next[k], qa_next[k]} = div_step(16'd0, in_num_a, divisor);
                assign {rb_next[k], qb_next[k]} = div_step(16'd0, in_num_b, divisor);
                assign side_next[k] = in_side;
                assign vld_next[k]  = in_valid;
            end else begin : g_rest
                assign {ra_next[k], qa_next[k]} = div_step(ra_reg[k-1], qa_reg[k-1], divisor);
                assign {rb_next[k], qb_next[k]} = div_step(rb_reg[k-1], qb_reg[k-1], divisor);
                assign side_next[k] = side_reg[k-1];
                assign vld_next[k]  = vld_reg[k-1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_next[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    ra_reg[k]   <= ra_next[k];
                    qa_reg[k]   <= qa_next[k];
                    rb_reg[k]   <= rb_next[k];
                    qb_reg[k]   <= qb_next[k];
                    side_reg[k] <= side_next[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W-1];
    assign out_q_a   = qa_reg[W-1];
    assign out_q_b   = qb_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule

// ===== hw/rtl/gb_energy_mobility_from_misorientation.sv =====
// ----------------------------------------------------------------------------
// gb_energy_mobility_from_misorientation
// Read-Shockley boundary energy and sigmoidal mobility from a misorientation
// angle.
// ----------------------------------------------------------------------------
// One angle enters per clock and its energy and mobility leave through six
// stages of log evaluation and multiply, fifty stages of the bit-per-stage
// divider by the reference angle, six stages of power, exp lookup and
// scaling, and the output register. Throughput is one transaction
// per cycle whenever the result side takes data; a stall on m_ready freezes
// the whole pipeline. Configuration registers are read live and must only be
// written while the pipeline is empty.
module gb_energy_mobility_from_misorientation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_energy,
    output logic [31:0] m_mobility,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LB = gbem_pkg::LOG_BITS;
    localparam int EB = gbem_pkg::EXP_BITS;

    logic [15:0] ref_angle_reg;
    logic [15:0] ref_energy_reg;
    logic [31:0] ref_mobility_reg;
    logic [15:0] refe;
    logic        en;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_angle_reg    <= 16'd3840;
            ref_energy_reg   <= 16'd14746;
            ref_mobility_reg <= 32'd2748779;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                gbem_pkg::REG_ANGLE:    ref_angle_reg    <= pwdata[15:0];
                gbem_pkg::REG_ENERGY:   ref_energy_reg   <= pwdata[15:0];
                gbem_pkg::REG_MOBILITY: ref_mobility_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gbem_pkg::REG_ANGLE:    prdata = {16'd0, ref_angle_reg};
            gbem_pkg::REG_ENERGY:   prdata = {16'd0, ref_energy_reg};
            gbem_pkg::REG_MOBILITY: prdata = ref_mobility_reg;
            default:                prdata = 32'd0;
        endcase
    end

    assign refe    = (ref_angle_reg == 16'd0) ? 16'd1 : ref_angle_reg;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    function automatic logic [3:0] lead_one(input logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    // log evaluation, lane 0 the angle, lane 1 the reference
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [15:0] ang1_reg, ang2_reg, ang3_reg, ang4_reg, ang5_reg;
    logic [3:0]  lp1_reg   [0:1];
    logic [15:0] lf1_reg   [0:1];
    logic [3:0]  lp_next   [0:1];
    logic [15:0] lf_next   [0:1];
    logic [33:0] lpl2_reg  [0:1];
    logic [30:0] la2_reg   [0:1];
    logic [30:0] ld2_reg   [0:1];
    logic [15:0] lfr2_reg  [0:1];
    logic [33:0] lsum3_reg [0:1];
    logic [46:0] lprd3_reg [0:1];
    logic [33:0] ln4_reg   [0:1];
    logic        neg5_reg;
    logic [33:0] mag5_reg;
    logic [35:0] om_next;

    always_comb begin
        logic [15:0] lv [0:1];
        logic [31:0] sh;
        lv[0] = s_angle;
        lv[1] = refe;
        for (int l = 0; l < 2; l++) begin
            lp_next[l] = lead_one(lv[l]);
            sh         = {lv[l], 16'd0} >> lp_next[l];
            lf_next[l] = sh[15:0];
        end
    end

    assign om_next = 36'(64'd1 << 30) - {2'b00, ln4_reg[0]} + {2'b00, ln4_reg[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [LB:0] idx;
        if (en) begin
            ang1_reg <= s_angle;
            ang2_reg <= ang1_reg;
            ang3_reg <= ang2_reg;
            ang4_reg <= ang3_reg;
            ang5_reg <= ang4_reg;
            for (int l = 0; l < 2; l++) begin
                lp1_reg[l]   <= lp_next[l];
                lf1_reg[l]   <= lf_next[l];
                idx          = {1'b0, lf1_reg[l][15:16-LB]};
                lpl2_reg[l]  <= 34'(lp1_reg[l]) * 34'(gbem_pkg::LN_ROM[gbem_pkg::LOG_DEPTH]);
                la2_reg[l]   <= gbem_pkg::LN_ROM[idx];
                ld2_reg[l]   <= gbem_pkg::LN_ROM[idx + 1'b1] - gbem_pkg::LN_ROM[idx];
                lfr2_reg[l]  <= 16'({lf1_reg[l], LB'(0)});
                lsum3_reg[l] <= lpl2_reg[l] + 34'(la2_reg[l]);
                lprd3_reg[l] <= 47'(ld2_reg[l]) * 47'(lfr2_reg[l]);
                ln4_reg[l]   <= lsum3_reg[l] + 34'(lprd3_reg[l][46:16]);
            end
            neg5_reg <= om_next[35];
            mag5_reg <= om_next[35] ? 34'(-om_next) : om_next[33:0];
        end
    end

    // product and divider inputs
    logic                       v6_reg;
    logic [49:0]                prd6_reg;
    logic [49:0]                numb6_reg;
    gbem_pkg::side_t            side6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prd6_reg       <= 50'(ang5_reg) * 50'(mag5_reg);
            numb6_reg      <= 50'({ang5_reg, 16'd0});
            side6_reg.zero <= (ang5_reg == 16'd0);
            side6_reg.gt   <= (ang5_reg > refe);
            side6_reg.neg  <= neg5_reg;
        end
    end

    logic            dv;
    logic [49:0]     dqa;
    logic [49:0]     dqb;
    gbem_pkg::side_t dside;

    gbem_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num_a  (prd6_reg),
        .in_num_b  (numb6_reg),
        .in_side   (side6_reg),
        .divisor   (refe),
        .out_valid (dv),
        .out_q_a   (dqa),
        .out_q_b   (dqb),
        .out_side  (dside)
    );

    // scaling, power, exp lookup
    logic            t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    gbem_pkg::side_t s1_reg, s2_reg;
    logic            gt3_reg, gt4_reg, gt5_reg, gt6_reg;
    logic [35:0]     qhs1_reg;
    logic [45:0]     qls1_reg;
    logic [16:0]     x2_1_reg;
    logic [16:0]     x4_2_reg;
    logic [31:0]     en2_reg, en3_reg, en4_reg, en5_reg, en6_reg;
    logic [30:0]     ea3_reg, ea4_reg;
    logic [30:0]     ed3_reg;
    logic [15:0]     efr3_reg;
    logic [46:0]     eprd4_reg;
    logic [30:0]     onem5_reg;
    logic [62:0]     mprd6_reg;
    logic [33:0]     x_sq;
    logic [33:0]     x2_sq;
    logic [36:0]     res;
    logic [36:0]     res_n;
    logic [31:0]     energy_next;
    logic [19:0]     p5;
    logic [31:0]     pos;
    logic [15:0]     eidx_full;
    logic [EB:0]     eidx;
    logic            esat;
    logic [30:0]     e_val;

    assign x_sq  = 34'(dqb[16:0]) * 34'(dqb[16:0]);
    assign x2_sq = 34'(x2_1_reg) * 34'(x2_1_reg);
    assign res   = 37'(qhs1_reg) + 37'(qls1_reg[45:30]);
    assign res_n = (res > 37'h0_8000_0000) ? 37'h0_8000_0000 : res;

    always_comb begin
        if (s1_reg.zero) begin
            energy_next = 32'd0;
        end else if (!s1_reg.neg) begin
            energy_next = (res > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
        end else begin
            energy_next = 32'd0 - res_n[31:0];
        end
    end

    assign p5        = {1'b0, x4_2_reg, 2'b00} + 20'(x4_2_reg);
    assign pos       = (32'(p5) << EB) >> 3;
    assign eidx_full = pos[31:16];
    assign esat      = (eidx_full >= 16'(gbem_pkg::EXP_DEPTH));
    assign eidx      = {1'b0, eidx_full[EB-1:0]};
    assign e_val     = ea4_reg - eprd4_reg[46:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= 1'b0;
            t2_reg <= 1'b0;
            t3_reg <= 1'b0;
            t4_reg <= 1'b0;
            t5_reg <= 1'b0;
            t6_reg <= 1'b0;
        end else if (en) begin
            t1_reg <= dv;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
            t6_reg <= t5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg    <= dside;
            qhs1_reg  <= 36'(dqa[49:30]) * 36'(ref_energy_reg);
            qls1_reg  <= 46'(dqa[29:0]) * 46'(ref_energy_reg);
            x2_1_reg  <= x_sq[32:16];

            s2_reg    <= s1_reg;
            en2_reg   <= energy_next;
            x4_2_reg  <= x2_sq[32:16];

            gt3_reg   <= s2_reg.gt;
            en3_reg   <= en2_reg;
            efr3_reg  <= esat ? 16'd0 : pos[15:0];
            ea3_reg   <= esat ? gbem_pkg::EXP_ROM[gbem_pkg::EXP_DEPTH]
                              : gbem_pkg::EXP_ROM[eidx];
            ed3_reg   <= esat ? 31'd0
                              : gbem_pkg::EXP_ROM[eidx] - gbem_pkg::EXP_ROM[eidx + 1'b1];

            gt4_reg   <= gt3_reg;
            en4_reg   <= en3_reg;
            ea4_reg   <= ea3_reg;
            eprd4_reg <= 47'(ed3_reg) * 47'(efr3_reg);

            gt5_reg   <= gt4_reg;
            en5_reg   <= en4_reg;
            onem5_reg <= 31'(64'd1 << 30) - e_val;

            gt6_reg   <= gt5_reg;
            en6_reg   <= en5_reg;
            mprd6_reg <= 63'(ref_mobility_reg) * 63'(onem5_reg);
        end
    end

    // output register
    logic        m_valid_reg;
    logic [31:0] m_energy_reg;
    logic [31:0] m_mobility_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= t6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_energy_reg   <= en6_reg;
            m_mobility_reg <= gt6_reg ? ref_mobility_reg : mprd6_reg[61:30];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_energy   = m_energy_reg;
    assign m_mobility = m_mobility_reg;

endmodule
